>>> hw/rtl/hufd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hufd_pkg;

    localparam int NODE_COUNT_DEF = 1024;

    localparam int IDX_W   = 10;
    localparam int SYM_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // result buffer entries behind the walk stage
    localparam int OUT_DEPTH = 3;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_SYMBOL = 2'd1;

    localparam logic [IDX_W-1:0] ROOT_RESET    = 10'd0;
    localparam logic [SYM_W-1:0] END_SYM_RESET = 9'd256;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [IDX_W-1:0] node_index;
        logic             node_leaf;
        logic [SYM_W-1:0] node_symbol;
        logic [IDX_W-1:0] zero_child;
        logic [IDX_W-1:0] one_child;
        logic             code_bit;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] symbol;
    } t_out_item;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] child0;
        logic [IDX_W-1:0] child1;
    } t_node;

endpackage

`default_nettype wire

>>> hw/rtl/hufd_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hufd_out_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire hufd_pkg::t_out_item i_push_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output hufd_pkg::t_out_item      o_item,
    output logic [$clog2(hufd_pkg::OUT_DEPTH+1)-1:0] o_count
);

    localparam int DEPTH = hufd_pkg::OUT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH-1);

    hufd_pkg::t_out_item r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic pop;

    assign pop     = (r_count != '0) && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_item  = r_buf[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/huffman_tree_walk_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A result item is registered in the walk stage and then in the result buffer before it appears.
// Throughput: one item per cycle while o_in_stall is low; a decode bit reads one child record
// from the node memory, and the walk stage forwards that record to the next bit in the same cycle.
// A root_index write holds the input side for one cycle while the root record is read.
// Reset (synchronous, active low) resets the walk state and the root and end-symbol registers; the node memory
// is not cleared and holds garbage until written.
module huffman_tree_walk_decoder_unit #(
    parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire hufd_pkg::t_in_item                  i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output hufd_pkg::t_out_item                      o_out_item,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [hufd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hufd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int IDX_W = hufd_pkg::IDX_W;
    localparam int CNT_W = $clog2(hufd_pkg::OUT_DEPTH+1);

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        idx_ok = (32'(idx) < NODE_COUNT);
    endfunction

    // node memory
    hufd_pkg::t_node r_mem [NODE_COUNT];
    hufd_pkg::t_node r_rd_data;
    logic            r_rd_inrng;
    logic            mem_we;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [IDX_W-1:0] rd_idx;
    hufd_pkg::t_node wr_node;

    // architectural state
    logic [IDX_W-1:0]           r_root_idx, n_root_idx;
    logic [hufd_pkg::SYM_W-1:0] r_end_sym;
    logic [IDX_W-1:0]           r_cur_idx, n_cur_idx;
    hufd_pkg::t_node            r_cur_rec, n_cur_rec;
    hufd_pkg::t_node            r_root_rec, n_root_rec;
    logic                       r_ended, n_ended;
    logic                       r_reload;

    // walk stage
    logic                          r_s2_valid;
    logic                          r_s2_walk, n_s2_walk;
    logic [hufd_pkg::KIND_W-1:0]   r_s2_kind, n_s2_kind;
    logic [IDX_W-1:0]              r_s2_next, n_s2_next;

    logic in_accept, cfg_accept, cfg_root_wr;
    hufd_pkg::t_node there;
    logic [IDX_W-1:0] eff_cur_idx;
    hufd_pkg::t_node  eff_cur_rec, eff_root_rec;
    logic             eff_ended;
    hufd_pkg::t_out_item s2_item;
    logic [CNT_W-1:0] fifo_count;
    logic [CNT_W:0]   in_flight;
    logic [IDX_W-1:0] walk_next;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = !r_reload;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign cfg_root_wr = cfg_accept && (i_cfg_index == hufd_pkg::CFG_ROOT_INDEX);

    assign in_flight  = {1'b0, fifo_count} + (CNT_W+1)'(r_s2_valid);
    assign o_in_stall = r_reload || (in_flight >= (CNT_W+1)'(hufd_pkg::OUT_DEPTH));

    assign there = r_rd_inrng ? r_rd_data : '0;

    // resolve the walk stage (and a root reload) into the state the next item sees
    always_comb begin
        eff_cur_idx  = r_cur_idx;
        eff_cur_rec  = r_cur_rec;
        eff_root_rec = r_root_rec;
        eff_ended    = r_ended;
        s2_item.kind   = r_s2_kind;
        s2_item.symbol = '0;
        if (r_reload) begin
            eff_root_rec = there;
            eff_cur_rec  = there;
        end
        if (r_s2_valid && r_s2_walk) begin
            if (there.leaf) begin
                eff_cur_idx = r_root_idx;
                eff_cur_rec = r_root_rec;
                if (there.sym == r_end_sym) begin
                    s2_item.kind = hufd_pkg::KIND_END;
                    eff_ended    = 1'b1;
                end else begin
                    s2_item.kind   = hufd_pkg::KIND_SYMBOL;
                    s2_item.symbol = there.sym[hufd_pkg::BYTE_W-1:0];
                end
            end else begin
                s2_item.kind = hufd_pkg::KIND_NONE;
                eff_cur_idx  = r_s2_next;
                eff_cur_rec  = there;
            end
        end
    end

    assign walk_next = i_in_item.code_bit ? eff_cur_rec.child1 : eff_cur_rec.child0;

    always_comb begin
        wr_node.leaf   = i_in_item.node_leaf;
        wr_node.sym    = i_in_item.node_symbol;
        wr_node.child0 = i_in_item.zero_child;
        wr_node.child1 = i_in_item.one_child;
    end

    always_comb begin
        n_root_idx = r_root_idx;
        n_cur_idx  = eff_cur_idx;
        n_cur_rec  = eff_cur_rec;
        n_root_rec = eff_root_rec;
        n_ended    = eff_ended;
        n_s2_walk  = 1'b0;
        n_s2_kind  = hufd_pkg::KIND_NONE;
        n_s2_next  = walk_next;
        mem_we     = 1'b0;
        rd_idx     = walk_next;
        if (in_accept) begin
            case (i_in_item.opcode)
                hufd_pkg::OP_WRITE: begin
                    if (idx_ok(i_in_item.node_index)) begin
                        mem_we = 1'b1;
                        if (i_in_item.node_index == r_root_idx) begin
                            n_root_rec = wr_node;
                        end
                        if (i_in_item.node_index == eff_cur_idx) begin
                            n_cur_rec = wr_node;
                        end
                    end
                end
                hufd_pkg::OP_DECODE: begin
                    if (!eff_ended) begin
                        if (eff_cur_rec.leaf) begin
                            n_s2_kind = hufd_pkg::KIND_ERROR;
                        end else begin
                            n_s2_walk = 1'b1;
                        end
                    end
                end
                hufd_pkg::OP_RESTART: begin
                    n_cur_idx = r_root_idx;
                    n_cur_rec = eff_root_rec;
                    n_ended   = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (cfg_root_wr) begin
            n_root_idx = i_cfg_data;
            n_cur_idx  = i_cfg_data;
            rd_idx     = i_cfg_data;
        end
    end

    assign wr_addr = AW'(i_in_item.node_index);
    assign rd_addr = AW'(rd_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_node;
        end
        r_rd_data  <= r_mem[rd_addr];
        r_rd_inrng <= idx_ok(rd_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_idx <= hufd_pkg::ROOT_RESET;
            r_end_sym  <= hufd_pkg::END_SYM_RESET;
            r_cur_idx  <= hufd_pkg::ROOT_RESET;
            r_cur_rec  <= '0;
            r_root_rec <= '0;
            r_ended    <= 1'b0;
            r_reload   <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_walk  <= 1'b0;
            r_s2_kind  <= hufd_pkg::KIND_NONE;
        end else begin
            r_root_idx <= n_root_idx;
            r_cur_idx  <= n_cur_idx;
            r_cur_rec  <= n_cur_rec;
            r_root_rec <= n_root_rec;
            r_ended    <= n_ended;
            r_reload   <= cfg_root_wr;
            r_s2_valid <= in_accept;
            r_s2_walk  <= n_s2_walk;
            r_s2_kind  <= n_s2_kind;
            if (cfg_accept && (i_cfg_index == hufd_pkg::CFG_END_SYMBOL)) begin
                r_end_sym <= i_cfg_data[hufd_pkg::SYM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_next <= n_s2_next;
    end

    hufd_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s2_valid),
        .i_push_item (s2_item),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item),
        .o_count     (fifo_count)
    );

endmodule

`default_nettype wire

>>> hw/rtl/hufd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hufd_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire hufd_pkg::t_out_item             o_out_item,
    input wire logic                            i_cfg_valid,
    input wire logic                            o_cfg_ready,
    input wire logic [hufd_pkg::CFG_IDX_W-1:0]  i_cfg_index
);

    logic in_acc, cfg_acc;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    a_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind != hufd_pkg::KIND_SYMBOL) |-> o_out_item.symbol == '0)
        else $error("symbol nonzero on a non-symbol result");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_acc, 2))
        else $error("result item without an accepted item two cycles before");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> $past(cfg_acc) && ($past(i_cfg_index) == hufd_pkg::CFG_ROOT_INDEX))
        else $error("config port blocked without a root write");

    a_reload_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> o_in_stall)
        else $error("input open during root reload");

endmodule

bind huffman_tree_walk_decoder_unit hufd_checker u_hufd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index)
);

`default_nettype wire

>>> sim/hufd_walk_checker.sv
`timescale 1ns / 1ps

module hufd_walk_checker
    import hufd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire t_out_item             i_out_item,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_errors,
    output int                         o_results
);

    // shadow of the decoder state
    t_node            tree_nodes [NODE_COUNT_DEF];
    logic [IDX_W-1:0] walk_node;
    logic [IDX_W-1:0] root_sel;
    logic [SYM_W-1:0] end_sym;
    logic             stream_done;

    t_out_item pending_results [$];
    t_out_item want;

    function automatic t_out_item walk_step(input t_in_item it);
        t_out_item        res;
        t_node            here;
        t_node            there;
        logic [IDX_W-1:0] nxt;
        res.kind   = KIND_NONE;
        res.symbol = '0;
        case (it.opcode)
            OP_WRITE: begin
                tree_nodes[it.node_index] = '{leaf: it.node_leaf, sym: it.node_symbol,
                                              child0: it.zero_child, child1: it.one_child};
            end
            OP_DECODE: begin
                // bits after the end symbol are dropped until a restart
                if (!stream_done) begin
                    here = tree_nodes[walk_node];
                    if (here.leaf) begin
                        res.kind = KIND_ERROR;
                    end else begin
                        nxt   = it.code_bit ? here.child1 : here.child0;
                        there = tree_nodes[nxt];
                        if (!there.leaf) begin
                            walk_node = nxt;
                        end else if (there.sym == end_sym) begin
                            res.kind    = KIND_END;
                            stream_done = 1'b1;
                            walk_node   = root_sel;
                        end else begin
                            res.kind   = KIND_SYMBOL;
                            res.symbol = there.sym[BYTE_W-1:0];
                            walk_node  = root_sel;
                        end
                    end
                end
            end
            OP_RESTART: begin
                walk_node   = root_sel;
                stream_done = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            walk_node   = ROOT_RESET;
            root_sel    = ROOT_RESET;
            end_sym     = END_SYM_RESET;
            stream_done = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ROOT_INDEX) begin
                    root_sel  = i_cfg_data[IDX_W-1:0];
                    walk_node = i_cfg_data[IDX_W-1:0];
                end else if (i_cfg_index == CFG_END_SYMBOL) begin
                    end_sym = i_cfg_data[SYM_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(walk_step(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (pending_results.size() == 0) begin
                    $error("result item with nothing pending: kind %0d symbol %0d",
                           i_out_item.kind, i_out_item.symbol);
                    o_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_item.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_out_item.kind);
                        o_errors++;
                    end
                    if (i_out_item.symbol !== want.symbol) begin
                        $error("symbol: expected %0d, got %0d", want.symbol,
                               i_out_item.symbol);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

>>> sim/huffman_tree_walk_decoder_unit_tb.sv
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_unit_tb;
    import hufd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1400;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int pending;
    int errors;
    int results;

    // generator bookkeeping: every interior node only points at written entries
    bit node_seen [NODE_COUNT_DEF];
    int seen_list [$];
    bit tree_slot [NODE_COUNT_DEF];

    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    bit hold_req = 1'b0;
    int n_writes = 0;
    int n_decodes = 0;
    int n_restarts = 0;
    int n_unused = 0;
    int n_settings = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    huffman_tree_walk_decoder_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    hufd_walk_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_results   (results)
    );

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_in_item rand_item(input logic [OP_W-1:0] op);
        logic [63:0] raw;
        t_in_item    it;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.opcode = op;
        return it;
    endfunction

    function automatic int pick_seen();
        return seen_list[$urandom_range(0, seen_list.size() - 1)];
    endfunction

    // fresh index for the tree being built; the top may land on an edge index
    function automatic int fresh_slot(input bit want_edge);
        int cand;
        if (want_edge && $urandom_range(0, 2) == 0) begin
            cand = $urandom_range(0, 1) ? NODE_COUNT_DEF - 1 : 0;
            if (!tree_slot[cand]) begin
                tree_slot[cand] = 1'b1;
                return cand;
            end
        end
        do cand = $urandom_range(0, NODE_COUNT_DEF - 1); while (tree_slot[cand]);
        tree_slot[cand] = 1'b1;
        return cand;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        case (it.opcode)
            OP_WRITE: begin
                n_writes++;
                if (!node_seen[it.node_index]) begin
                    node_seen[it.node_index] = 1'b1;
                    seen_list.push_back(int'(it.node_index));
                end
            end
            OP_DECODE:  n_decodes++;
            OP_RESTART: n_restarts++;
            default:    n_unused++;
        endcase
    endtask

    task automatic put_node(input int idx, input bit leaf, input int sym,
                            input int c0, input int c1);
        t_in_item it;
        it = rand_item(OP_WRITE);
        it.node_index  = IDX_W'(idx);
        it.node_leaf   = leaf;
        it.node_symbol = SYM_W'(sym);
        it.zero_child  = IDX_W'(c0);
        it.one_child   = IDX_W'(c1);
        send_item(it);
    endtask

    task automatic decode_bit(input bit b);
        t_in_item it;
        it = rand_item(OP_DECODE);
        it.code_bit = b;
        send_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let every pending result drain before touching the registers
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Huffman-style build: leaves first, then pairs merged bottom-up
    task automatic grow_tree(input int stop_sym, output int top);
        int n;
        int pos;
        int a;
        int b;
        int idx;
        int pool [$];
        foreach (tree_slot[i]) tree_slot[i] = 1'b0;
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
        for (int k = 0; k < n; k++) begin
            idx = fresh_slot(n == 1);
            put_node(idx, 1'b1, ($urandom_range(0, 3) == 0) ? stop_sym
                                                             : $urandom_range(0, 511),
                     pick_seen(), pick_seen());
            pool.push_back(idx);
        end
        while (pool.size() > 1) begin
            pos = $urandom_range(0, pool.size() - 1);
            a = pool[pos];
            pool.delete(pos);
            pos = $urandom_range(0, pool.size() - 1);
            b = pool[pos];
            pool.delete(pos);
            idx = fresh_slot(pool.size() == 0);
            put_node(idx, 1'b0, ($urandom_range(0, 3) == 0) ? stop_sym
                                                             : $urandom_range(0, 511),
                     a, b);
            pool.push_back(idx);
        end
        top = pool[0];
    endtask

    // output side: random stalls, quiet stretches, one long hold
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 31) == 0) rx_eager = !rx_eager;
                gap = rx_eager ? 0 : $urandom_range(0, 5);
            end
            repeat (gap) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int tree_top;
        int stop_sym;
        int len;
        int r;
        int phase;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // hand-built tree under reset settings (root 0, end symbol 256)
        put_node(NODE_COUNT_DEF - 1, 1'b1, 8'h41, NODE_COUNT_DEF - 1, 0);
        put_node(1, 1'b1, 256, 0, NODE_COUNT_DEF - 1);
        put_node(2, 1'b1, 511, 0, 0);
        put_node(3, 1'b0, 256, 2, 1);
        put_node(0, 1'b0, 511, NODE_COUNT_DEF - 1, 3);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b1);
        decode_bit(1'b0);
        send_item(rand_item(OP_RESTART));
        decode_bit(1'b1);
        // current node turns into a leaf mid-walk, so the next bit is an error
        put_node(3, 1'b1, 0, 0, NODE_COUNT_DEF - 1);
        decode_bit(1'b1);
        send_item('1);
        send_item(rand_item(OP_RESTART));
        decode_bit(1'b1);
        put_node(0, 1'b0, 0, 1, 3);
        decode_bit(1'b0);
        settle();

        // one-leaf tree at the top index; stream stays ended across the root move
        write_reg(CFG_ROOT_INDEX, NODE_COUNT_DEF - 1);
        write_reg(CFG_END_SYMBOL, 'h200);
        n_settings++;
        decode_bit(1'b1);
        send_item(rand_item(OP_RESTART));
        decode_bit(1'b0);
        settle();

        write_reg(CFG_ROOT_INDEX, 0);
        write_reg(CFG_END_SYMBOL, 'h1FF);
        n_settings++;
        decode_bit(1'b1);
        decode_bit(1'b0);

        phase = 0;
        while (n_writes + n_decodes + n_restarts < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0:       stop_sym = 0;
                1:       stop_sym = 511;
                2:       stop_sym = 255;
                3:       stop_sym = 256;
                default: stop_sym = $urandom_range(0, 511);
            endcase
            tx_eager = ($urandom_range(0, 3) == 0);
            grow_tree(stop_sym, tree_top);
            settle();
            write_reg(CFG_ROOT_INDEX, tree_top);
            write_reg(CFG_END_SYMBOL, ($urandom_range(0, 1) << SYM_W) | stop_sym);
            n_settings++;
            if (phase == 2) begin
                tx_eager = 1'b1;
                hold_req = 1'b1;
            end
            len = $urandom_range(50, 110);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    decode_bit(1'($urandom_range(0, 1)));
                else if (r < 88)
                    send_item(rand_item(OP_RESTART));
                else if (r < 96)
                    put_node($urandom_range(0, 1) ? pick_seen()
                                                  : $urandom_range(0, NODE_COUNT_DEF - 1),
                             1'($urandom_range(0, 1)), $urandom_range(0, 511),
                             pick_seen(), pick_seen());
                else
                    send_item(rand_item(OP_UNUSED));
            end
            phase++;
        end
        settle();

        $display("Covered %0d node writes, %0d code bits, %0d restarts, %0d unused opcodes",
                 n_writes, n_decodes, n_restarts, n_unused);
        $display("over %0d register settings; %0d results compared, one %0d-cycle output hold",
                 n_settings, results, HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
